[src/cube_map_footprint_faces_assert.svh]
// ---------------------------------------------------------------------------
// cube_map_footprint_faces_assert.svh
// Assertion macros for the cube map footprint block; empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef CUBE_MAP_FOOTPRINT_FACES_ASSERT_SVH
`define CUBE_MAP_FOOTPRINT_FACES_ASSERT_SVH

`ifndef SYNTH
`define CMFF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cmff: implication check failed");
`define CMFF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cmff: next-cycle check failed");
`else
`define CMFF_ASSERT_IMPL(lbl, ante, cons)
`define CMFF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/cmff_pkg.sv]
// ---------------------------------------------------------------------------
// cmff_pkg
// Types, constants and face tables shared by the cube map footprint block.
// ---------------------------------------------------------------------------
package cmff_pkg;

  localparam int COORD_BITS = 16;
  localparam int CW     = 17;   // cube coordinate, Q16, range +-0.5
  localparam int MW     = 18;   // multiplier operand
  localparam int PW     = 36;   // multiplier product
  localparam int NW     = 33;   // plane normal component
  localparam int SW     = 34;   // normal sum
  localparam int UNW    = 48;   // divider numerator magnitude
  localparam int UDW    = 33;   // divider denominator magnitude
  localparam int QW     = 18;   // quotient bits
  localparam int RW     = 52;   // divider remainder
  localparam int LIST_N = 9;
  localparam int LW     = 4;

  localparam logic signed [CW-1:0] HALF_Q     = 17'sd32768;
  localparam logic [16:0]          ONE_Q      = 17'd65536;
  localparam logic [16:0]          RECIP3     = 17'd87382;  // ceil(2^18 / 3)
  localparam int                   RECIP3_SH  = 18;
  localparam logic [15:0]          COL_STEP   = 16'd21845;  // 65536 / 3
  localparam logic [15:0]          ROW_STEP   = 16'd32768;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [CW-1:0]         cc_t;
  typedef logic [2:0]                   face_t;
  typedef logic [1:0]                   axis_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  localparam face_t FACE_PZ = 3'd0;
  localparam face_t FACE_PX = 3'd1;
  localparam face_t FACE_PY = 3'd2;
  localparam face_t FACE_NX = 3'd3;
  localparam face_t FACE_NY = 3'd4;
  localparam face_t FACE_NZ = 3'd5;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CAX, S_CDGO, S_CDW, S_LINIT, S_LSTEP, S_XP, S_EPREP,
    S_EDW, S_LAPP, S_FINIT, S_FSEL, S_FSCAN, S_FAREA, S_FEMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       axis;
    logic       wr_zero;
    logic       div_start;
    logic       div_edge;
    logic       wr_ck;
    logic       wr_cm;
    logic       list_init;
    logic       app_corner;
    logic       xp;
    logic       wr_edge;
    logic       scan;
    logic       scan_first;
    logic       area;
    logic       emit;
    logic [1:0] ci;
    logic       kk;
    logic [2:0] step;
    logic [LW-1:0] j;
    face_t      f;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic div_done;
    logic face_diff;
    logic same_axis;
    logic nk_zero;
    logic mask_f;
    logic scan_last;
    logic last;
    logic out_free;
  } sts_t;

  typedef struct packed {
    face_t       face;
    logic [15:0] s_low;
    logic [15:0] s_high;
    logic [15:0] t_low;
    logic [15:0] t_high;
    logic [16:0] weight;
    logic        last;
    logic        bad_geometry;
  } res_t;

  function automatic axis_t face_axis(face_t f);
    case (f)
      FACE_PZ, FACE_NZ: return AXIS_Z;
      FACE_PX, FACE_NX: return AXIS_X;
      default:          return AXIS_Y;
    endcase
  endfunction

  function automatic logic face_neg(face_t f);
    case (f)
      FACE_NX, FACE_NY, FACE_NZ: return 1'b1;
      default:                   return 1'b0;
    endcase
  endfunction

  function automatic axis_t u_axis(face_t f);
    case (f)
      FACE_PX, FACE_NX: return AXIS_Z;
      default:          return AXIS_X;
    endcase
  endfunction

  function automatic logic u_neg(face_t f);
    case (f)
      FACE_PX, FACE_NZ: return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic axis_t v_axis(face_t f);
    case (f)
      FACE_PY, FACE_NY: return AXIS_Z;
      default:          return AXIS_Y;
    endcase
  endfunction

  function automatic logic v_neg(face_t f);
    case (f)
      FACE_PY: return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic [1:0] face_col(face_t f);
    case (f)
      FACE_PZ, FACE_NX: return 2'd0;
      FACE_PX, FACE_NY: return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  function automatic logic face_row(face_t f);
    case (f)
      FACE_NX, FACE_NY, FACE_NZ: return 1'b1;
      default:                   return 1'b0;
    endcase
  endfunction

  function automatic coord_t vec_axis(vec_t v, axis_t a);
    case (a)
      AXIS_X:  return v.x;
      AXIS_Y:  return v.y;
      default: return v.z;
    endcase
  endfunction

endpackage

[src/cmff_in_if.sv]
// ---------------------------------------------------------------------------
// cmff_in_if
// Input channel: four corner direction vectors of one beam.
// ---------------------------------------------------------------------------
interface cmff_in_if
  import cmff_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t ax, ay, az;
  coord_t bx, by_comp, bz;
  coord_t cx, cy, cz;
  coord_t dx, dy, dz;

  modport source (output valid, ax, ay, az, bx, by_comp, bz, cx, cy, cz, dx, dy, dz,
                  input ready);
  modport sink   (input valid, ax, ay, az, bx, by_comp, bz, cx, cy, cz, dx, dy, dz,
                  output ready);
endinterface

[src/cmff_out_if.sv]
// ---------------------------------------------------------------------------
// cmff_out_if
// Result channel: one atlas rectangle and weight per touched face.
// ---------------------------------------------------------------------------
interface cmff_out_if
  import cmff_pkg::*;
();
  logic        valid;
  logic        ready;
  face_t       face;
  logic [15:0] s_low;
  logic [15:0] s_high;
  logic [15:0] t_low;
  logic [15:0] t_high;
  logic [16:0] weight;
  logic        last;
  logic        bad_geometry;

  modport source (output valid, face, s_low, s_high, t_low, t_high, weight, last,
                  bad_geometry, input ready);
  modport sink   (input valid, face, s_low, s_high, t_low, t_high, weight, last,
                  bad_geometry, output ready);
endinterface

[src/cmff_div.sv]
// ---------------------------------------------------------------------------
// cmff_div
// Iterative rounding divider: q = (2n + d) / (2d), one quotient bit a cycle,
// saturating to all ones when the quotient does not fit.
// ---------------------------------------------------------------------------
`include "cube_map_footprint_faces_assert.svh"

module cmff_div
  import cmff_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [UNW-1:0] un,
  input  logic [UDW-1:0] ud,
  output logic           done,
  output logic [QW-1:0]  q
);

  logic          busy_r;
  logic          done_r;
  logic [4:0]    cnt_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] dsh_r;
  logic [QW-1:0] q_r;

  logic [RW-1:0] nn;
  logic [RW-1:0] dd;
  logic          ovf;
  logic          ge;

  assign nn  = (RW'(un) << 1) + RW'(ud);
  assign dd  = RW'(ud) << 1;
  assign ovf = nn >= (dd << QW);
  assign ge  = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !ovf;
        done_r <= ovf;
      end else if (busy_r && cnt_r == 5'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= nn;
      dsh_r <= dd << (QW - 1);
      cnt_r <= 5'(QW - 1);
      q_r   <= ovf ? '1 : '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - dsh_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[QW-2:0], ge};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign done = done_r;
  assign q    = q_r;

  `CMFF_ASSERT_IMPL(a_start_idle, start, !busy_r)
  `CMFF_ASSERT_NEXT(a_done_pulse, done_r, !done_r)

endmodule

[src/cmff_ctrl.sv]
// ---------------------------------------------------------------------------
// cmff_ctrl
// Sequencer: corner projection, outline build, per-face box and emit.
// ---------------------------------------------------------------------------
module cmff_ctrl
  import cmff_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t        state_r, state_nxt;
  logic [1:0]    ci_r, ci_nxt;
  logic          kk_r, kk_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [LW-1:0] j_r, j_nxt;
  face_t         f_r, f_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ci_r    <= '0;
      kk_r    <= 1'b0;
      step_r  <= '0;
      j_r     <= '0;
      f_r     <= FACE_PZ;
    end else begin
      state_r <= state_nxt;
      ci_r    <= ci_nxt;
      kk_r    <= kk_nxt;
      step_r  <= step_nxt;
      j_r     <= j_nxt;
      f_r     <= f_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ci_nxt    = ci_r;
    kk_nxt    = kk_r;
    step_nxt  = step_r;
    j_nxt     = j_r;
    f_nxt     = f_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.ci    = ci_r;
    cmd.kk    = kk_r;
    cmd.step  = step_r;
    cmd.j     = j_r;
    cmd.f     = f_r;
    cmd.scan_first = (j_r == '0);
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          ci_nxt    = '0;
          state_nxt = S_CAX;
        end
      end
      S_CAX: begin
        if (sts.zero) begin
          cmd.wr_zero = 1'b1;
          if (ci_r == 2'd3) state_nxt = S_LINIT;
          else ci_nxt = ci_r + 2'd1;
        end else begin
          cmd.axis  = 1'b1;
          kk_nxt    = 1'b0;
          state_nxt = S_CDGO;
        end
      end
      S_CDGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_CDW;
      end
      S_CDW: begin
        if (sts.div_done) begin
          cmd.wr_ck = 1'b1;
          if (kk_r) begin
            cmd.wr_cm = 1'b1;
            if (ci_r == 2'd3) begin
              state_nxt = S_LINIT;
            end else begin
              ci_nxt    = ci_r + 2'd1;
              state_nxt = S_CAX;
            end
          end else begin
            kk_nxt    = 1'b1;
            state_nxt = S_CDGO;
          end
        end
      end
      S_LINIT: begin
        cmd.list_init = 1'b1;
        ci_nxt        = '0;
        state_nxt     = S_LSTEP;
      end
      S_LSTEP: begin
        if (sts.face_diff && !sts.same_axis) begin
          step_nxt  = '0;
          state_nxt = S_XP;
        end else begin
          cmd.app_corner = 1'b1;
          if (ci_r == 2'd3) state_nxt = S_FINIT;
          else ci_nxt = ci_r + 2'd1;
        end
      end
      S_XP: begin
        cmd.xp   = 1'b1;
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd6) state_nxt = S_EPREP;
      end
      S_EPREP: begin
        if (sts.nk_zero) begin
          cmd.wr_edge = 1'b1;
          state_nxt   = S_LAPP;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_edge  = 1'b1;
          state_nxt     = S_EDW;
        end
      end
      S_EDW: begin
        if (sts.div_done) begin
          cmd.wr_edge = 1'b1;
          state_nxt   = S_LAPP;
        end
      end
      S_LAPP: begin
        cmd.app_corner = 1'b1;
        if (ci_r == 2'd3) begin
          state_nxt = S_FINIT;
        end else begin
          ci_nxt    = ci_r + 2'd1;
          state_nxt = S_LSTEP;
        end
      end
      S_FINIT: begin
        f_nxt     = FACE_PZ;
        state_nxt = S_FSEL;
      end
      S_FSEL: begin
        if (sts.mask_f) begin
          j_nxt     = '0;
          state_nxt = S_FSCAN;
        end else if (f_r == FACE_NZ) begin
          state_nxt = S_IDLE;
        end else begin
          f_nxt = f_r + 3'd1;
        end
      end
      S_FSCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_FAREA;
        else j_nxt = j_r + 4'd1;
      end
      S_FAREA: begin
        cmd.area  = 1'b1;
        state_nxt = S_FEMIT;
      end
      S_FEMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_nxt = S_IDLE;
          end else begin
            f_nxt     = f_r + 3'd1;
            state_nxt = S_FSEL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[src/cmff_dp.sv]
// ---------------------------------------------------------------------------
// cmff_dp
// Datapath: corner and outline registers, shared multiplier and divider,
// face box accumulation and the result register.
// ---------------------------------------------------------------------------
`include "cube_map_footprint_faces_assert.svh"

module cmff_dp
  import cmff_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  vec_t [3:0] vin,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic       out_ready,
  output logic       out_valid,
  output res_t       res
);

  vec_t          vin_r  [4];
  cc_t           cor_r  [4][3];
  face_t         cface_r[4];
  cc_t           list_r [LIST_N][3];
  logic [LW-1:0] cnt_r;
  logic [5:0]    mask_r;
  logic          bad_r;

  axis_t                 m_r;
  logic                  sgn_r;
  logic [COORD_BITS-1:0] den_r;
  logic                  div_neg_r;
  axis_t                 div_k_r;

  logic signed [PW-1:0] prod_r;
  logic signed [NW-1:0] tmp_r;
  logic signed [NW-1:0] n_r[3];

  logic signed [CW:0] s1_r, s2_r, t1_r, t2_r;
  logic [15:0]        sl_r, sh_r, tl_r, th_r;
  res_t               out_r;
  logic               out_valid_r;

  // ---- corner projection --------------------------------------------------
  vec_t                  vc;
  coord_t                vcomp[3];
  logic [COORD_BITS-1:0] ab[3];
  logic                  zero_c;
  axis_t                 m_c;
  axis_t                 oth;
  coord_t                vo;
  logic [COORD_BITS-1:0] abo;

  always_comb begin
    vc = vin_r[cmd.ci];
    for (int k = 0; k < 3; k++) begin
      vcomp[k] = vec_axis(vc, axis_t'(k));
      ab[k] = vcomp[k][COORD_BITS-1] ? COORD_BITS'(-vcomp[k]) : COORD_BITS'(vcomp[k]);
    end
    zero_c = (ab[0] == '0) && (ab[1] == '0) && (ab[2] == '0);
    if (ab[2] >= ab[0] && ab[2] >= ab[1]) m_c = AXIS_Z;
    else if (ab[1] >= ab[0])              m_c = AXIS_Y;
    else                                  m_c = AXIS_X;
    if (!cmd.kk) oth = (m_r == AXIS_X) ? AXIS_Y : AXIS_X;
    else         oth = (m_r == AXIS_Z) ? AXIS_Y : AXIS_Z;
    vo  = vec_axis(vc, oth);
    abo = vo[COORD_BITS-1] ? COORD_BITS'(-vo) : COORD_BITS'(vo);
  end

  // ---- edge point between corner ci-1 and corner ci -------------------------
  logic [1:0]           pi;
  face_t                pf, qf;
  axis_t                ea1, ea2, ek;
  logic signed [SW-1:0] na1, na2, num;
  logic signed [NW-1:0] nk;
  logic [SW-1:0]        num_mag;
  logic [UDW-1:0]       nk_mag;
  logic                 num_pos;

  always_comb begin
    pi  = cmd.ci - 2'd1;
    pf  = cface_r[pi];
    qf  = cface_r[cmd.ci];
    ea1 = face_axis(pf);
    ea2 = face_axis(qf);
    ek  = 2'd3 - ea1 - ea2;
    na1 = SW'(n_r[ea1]);
    na2 = SW'(n_r[ea2]);
    num = (face_neg(pf) ? -na1 : na1) + (face_neg(qf) ? -na2 : na2);
    nk  = n_r[ek];
    num_mag = num[SW-1] ? SW'(-num) : SW'(num);
    nk_mag  = nk[NW-1] ? UDW'(-nk) : UDW'(nk);
    num_pos = !num[SW-1] && (num != '0);
  end

  // ---- divider ----------------------------------------------------------------
  logic [UNW-1:0] div_un;
  logic [UDW-1:0] div_ud;
  logic           div_done;
  logic [QW-1:0]  div_q;
  logic [CW-1:0]  q_clip;
  cc_t            div_res;

  assign div_un = cmd.div_edge ? (UNW'(num_mag) << 15) : (UNW'(abo) << 15);
  assign div_ud = cmd.div_edge ? nk_mag : UDW'(den_r);
  assign q_clip = (div_q > QW'(HALF_Q)) ? CW'(HALF_Q) : CW'(div_q);
  assign div_res = div_neg_r ? -cc_t'(q_clip) : cc_t'(q_clip);

  cmff_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .un    (div_un),
    .ud    (div_ud),
    .done  (div_done),
    .q     (div_q)
  );

  // ---- shared multiplier ---------------------------------------------------
  cc_t                  xa, xb;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [MW-1:0] ds, dt;

  always_comb begin
    case (cmd.step)
      3'd0:    begin xa = cor_r[pi][1]; xb = cor_r[cmd.ci][2]; end
      3'd1:    begin xa = cor_r[pi][2]; xb = cor_r[cmd.ci][1]; end
      3'd2:    begin xa = cor_r[pi][2]; xb = cor_r[cmd.ci][0]; end
      3'd3:    begin xa = cor_r[pi][0]; xb = cor_r[cmd.ci][2]; end
      3'd4:    begin xa = cor_r[pi][0]; xb = cor_r[cmd.ci][1]; end
      3'd5:    begin xa = cor_r[pi][1]; xb = cor_r[cmd.ci][0]; end
      default: begin xa = '0;           xb = '0;               end
    endcase
    ds    = s2_r - s1_r;
    dt    = t2_r - t1_r;
    mul_a = cmd.area ? ds : MW'(xa);
    mul_b = cmd.area ? dt : MW'(xb);
  end

  // ---- face scan ----------------------------------------------------------
  cc_t                eu, ev;
  logic signed [CW:0] uu, tt;

  always_comb begin
    eu = list_r[cmd.j][u_axis(cmd.f)];
    ev = list_r[cmd.j][v_axis(cmd.f)];
    uu = (u_neg(cmd.f) ? -(CW+1)'(eu) : (CW+1)'(eu)) + (CW+1)'(HALF_Q);
    tt = (v_neg(cmd.f) ? -(CW+1)'(ev) : (CW+1)'(ev)) + (CW+1)'(HALF_Q);
  end

  function automatic logic [16:0] clamp_uv(logic signed [CW:0] x);
    if (x < 0)                   return '0;
    if (x > $signed({1'b0, ONE_Q})) return ONE_Q;
    return x[16:0];
  endfunction

  // (u + col*65536 + 1) / 3 = col*21845 + (u + col + 1) / 3
  function automatic logic [15:0] atlas_s(logic [16:0] u, logic [1:0] col);
    logic [16:0] xs;
    logic [33:0] pr;
    logic [16:0] sum;
    xs  = u + 17'(col) + 17'd1;
    pr  = 34'(xs) * 34'(RECIP3);
    sum = 17'(pr >> RECIP3_SH) + 17'(col) * 17'(COL_STEP);
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  function automatic logic [15:0] atlas_t(logic [16:0] v, logic row);
    logic [16:0] sum;
    sum = ((v + 17'd1) >> 1) + (row ? 17'(ROW_STEP) : 17'd0);
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  // ---- weight from box area -------------------------------------------------
  logic [32:0] area;
  logic [33:0] area_rnd;
  logic [16:0] wgt;

  always_comb begin
    area     = prod_r[32:0];
    area_rnd = 34'(area) + 34'd32768;
    if (area == '0)                 wgt = ONE_Q;
    else if (area_rnd[33:16] == '0) wgt = 17'd1;
    else                            wgt = area_rnd[32:16];
  end

  // ---- control registers ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.list_init) begin
        cnt_r  <= LW'(1);
        mask_r <= 6'd1 << cface_r[3];
      end else if (cmd.app_corner || cmd.wr_edge) begin
        cnt_r <= cnt_r + LW'(1);
      end
      if (cmd.app_corner) mask_r <= mask_r | (6'd1 << cface_r[cmd.ci]);
      if (cmd.emit)        out_valid_r <= 1'b1;
      else if (out_ready)  out_valid_r <= 1'b0;
    end
  end

  // ---- payload registers ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 4; i++) vin_r[i] <= vin[i];
      bad_r <= 1'b0;
    end
    if (cmd.axis) begin
      m_r   <= m_c;
      sgn_r <= vcomp[m_c][COORD_BITS-1];
      den_r <= ab[m_c];
    end
    if (cmd.wr_zero) begin
      cor_r[cmd.ci][0] <= '0;
      cor_r[cmd.ci][1] <= '0;
      cor_r[cmd.ci][2] <= HALF_Q;
      cface_r[cmd.ci]  <= FACE_PZ;
      bad_r            <= 1'b1;
    end
    // corner divisions are by the major magnitude: sign comes from the numerator
    if (cmd.div_start) begin
      div_neg_r <= cmd.div_edge ? (num_pos ^ nk[NW-1]) : vo[COORD_BITS-1];
      div_k_r   <= oth;
    end
    if (cmd.wr_ck) cor_r[cmd.ci][div_k_r] <= div_res;
    if (cmd.wr_cm) begin
      cor_r[cmd.ci][m_r] <= sgn_r ? -HALF_Q : HALF_Q;
      case (m_r)
        AXIS_Z:  cface_r[cmd.ci] <= sgn_r ? FACE_NZ : FACE_PZ;
        AXIS_X:  cface_r[cmd.ci] <= sgn_r ? FACE_NX : FACE_PX;
        default: cface_r[cmd.ci] <= sgn_r ? FACE_NY : FACE_PY;
      endcase
    end
    if (cmd.list_init) begin
      for (int k = 0; k < 3; k++) list_r[0][k] <= cor_r[3][k];
    end
    if (cmd.app_corner) begin
      for (int k = 0; k < 3; k++) list_r[cnt_r][k] <= cor_r[cmd.ci][k];
      if (sts.face_diff && sts.same_axis) bad_r <= 1'b1;
    end
    if (cmd.wr_edge) begin
      list_r[cnt_r][ea1] <= face_neg(pf) ? -HALF_Q : HALF_Q;
      list_r[cnt_r][ea2] <= face_neg(qf) ? -HALF_Q : HALF_Q;
      list_r[cnt_r][ek]  <= (nk == '0) ? '0 : div_res;
    end
    if (cmd.xp || cmd.area) prod_r <= mul_a * mul_b;
    // products are registered, so each step uses the product of the step before: odd steps hold, even steps subtract
    if (cmd.xp && cmd.step != 3'd0) begin
      if (cmd.step[0]) tmp_r <= prod_r[NW-1:0];
      else             n_r[cmd.step[2:1] - 2'd1] <= tmp_r - prod_r[NW-1:0];
    end
    if (cmd.scan) begin
      if (cmd.scan_first || uu < s1_r) s1_r <= uu;
      if (cmd.scan_first || uu > s2_r) s2_r <= uu;
      if (cmd.scan_first || tt < t1_r) t1_r <= tt;
      if (cmd.scan_first || tt > t2_r) t2_r <= tt;
    end
    if (cmd.area) begin
      sl_r <= atlas_s(clamp_uv(s1_r), face_col(cmd.f));
      sh_r <= atlas_s(clamp_uv(s2_r), face_col(cmd.f));
      tl_r <= atlas_t(clamp_uv(t1_r), face_row(cmd.f));
      th_r <= atlas_t(clamp_uv(t2_r), face_row(cmd.f));
    end
    if (cmd.emit) begin
      out_r.face         <= cmd.f;
      out_r.s_low        <= sl_r;
      out_r.s_high       <= sh_r;
      out_r.t_low        <= tl_r;
      out_r.t_high       <= th_r;
      out_r.weight       <= wgt;
      out_r.last         <= sts.last;
      out_r.bad_geometry <= bad_r;
    end
  end

  // ---- status -------------------------------------------------------------
  always_comb begin
    sts.zero      = zero_c;
    sts.div_done  = div_done;
    sts.face_diff = (pf != qf);
    sts.same_axis = (ea1 == ea2);
    sts.nk_zero   = (nk == '0);
    sts.mask_f    = mask_r[cmd.f];
    sts.scan_last = (cmd.j == cnt_r - LW'(1));
    sts.last      = ((mask_r >> ({1'b0, cmd.f} + 4'd1)) == 6'd0);
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign res       = out_r;

  `CMFF_ASSERT_IMPL(a_list_bound, 1'b1, cnt_r <= LW'(LIST_N))
  `CMFF_ASSERT_IMPL(a_emit_face, cmd.emit, mask_r[cmd.f] && sts.out_free)

endmodule

[src/cube_map_footprint_faces.sv]
// ---------------------------------------------------------------------------
// cube_map_footprint_faces
// Cube map footprint: face rectangles and weights for one four-corner beam.
// ---------------------------------------------------------------------------
// One beam is taken at a time; the input is ready only while the block is
// idle. Every nonzero corner needs two divisions, a zero corner none, and
// every edge point between corners on adjacent faces a cross product plus one
// division unless the plane is parallel to that edge, all on a single shared
// divider that makes one quotient bit per cycle; then the faces are checked in
// turn, and each touched face scans its outline points (up to nine), takes its
// box and weight and is emitted once the result register is free. The result
// register lets the next beam start while the final rectangle waits.
module cube_map_footprint_faces
  import cmff_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cmff_in_if.sink    in_ch,
  cmff_out_if.source out_ch
);

  cmd_t       cmd;
  sts_t       sts;
  vec_t [3:0] vin;
  res_t       res;
  logic       in_ready;
  logic       out_valid;

  assign vin[0] = '{x: in_ch.ax, y: in_ch.ay,      z: in_ch.az};
  assign vin[1] = '{x: in_ch.bx, y: in_ch.by_comp, z: in_ch.bz};
  assign vin[2] = '{x: in_ch.cx, y: in_ch.cy,      z: in_ch.cz};
  assign vin[3] = '{x: in_ch.dx, y: in_ch.dy,      z: in_ch.dz};

  assign in_ch.ready = in_ready;

  cmff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  cmff_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .vin       (vin),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.face         = res.face;
  assign out_ch.s_low        = res.s_low;
  assign out_ch.s_high       = res.s_high;
  assign out_ch.t_low        = res.t_low;
  assign out_ch.t_high       = res.t_high;
  assign out_ch.weight       = res.weight;
  assign out_ch.last         = res.last;
  assign out_ch.bad_geometry = res.bad_geometry;

endmodule

[verif/cube_map_footprint_faces_test.sv]
// ---------------------------------------------------------------------------
// cube_map_footprint_faces_test
// Self-checking bench for the cube map footprint block. Beams go in through a
// directed table and then at random; a predictor works out the face rectangles
// of each accepted beam, and every returned rectangle is compared against them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cube_map_footprint_faces_test;
  import cmff_pkg::*;

  typedef struct {
    coord_t c[12];
  } beam_t;

  typedef struct {
    longint p[3];
    int     fc;
  } cpt_t;

  typedef struct {
    beam_t beam;
    logic  has_exp;  // first result typed in
    res_t  exp0;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cmff_in_if  in_ch ();
  cmff_out_if out_ch ();

  cube_map_footprint_faces i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  res_t   rect_q[$];
  row_t   rows[$];
  int     errors = 0;
  bit     send_done = 1'b0;
  bit     long_hold = 1'b0;

  localparam longint HQ = 32768;
  localparam longint OQ = 65536;

  function automatic longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint div_round(longint n, longint d);
    longint q;
    q = (2 * mag64(n) + mag64(d)) / (2 * mag64(d));
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic int axis_of(int f);
    return (f == 0 || f == 5) ? 2 : ((f == 1 || f == 3) ? 0 : 1);
  endfunction

  function automatic longint sign_of(int f);
    return f >= 3 ? -1 : 1;
  endfunction

  function automatic void project(coord_t x, coord_t y, coord_t z, ref cpt_t pt,
                                  ref bit bad);
    longint v[3];
    longint a[3];
    int m;
    longint s;
    v[0] = x; v[1] = y; v[2] = z;
    for (int k = 0; k < 3; k++) a[k] = mag64(v[k]);
    if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
      bad = 1'b1;
      pt.p[0] = 0; pt.p[1] = 0; pt.p[2] = HQ; pt.fc = 0;
      return;
    end
    if (a[2] >= a[0] && a[2] >= a[1]) m = 2;
    else if (a[1] >= a[0]) m = 1;
    else m = 0;
    s = v[m] > 0 ? 1 : -1;
    for (int k = 0; k < 3; k++)
      pt.p[k] = (k == m) ? s * HQ : div_round(v[k] * HQ, a[m]);
    if (m == 2) pt.fc = s > 0 ? 0 : 5;
    else if (m == 0) pt.fc = s > 0 ? 1 : 3;
    else pt.fc = s > 0 ? 2 : 4;
  endfunction

  function automatic cpt_t crossing(cpt_t p, cpt_t q);
    cpt_t e;
    int a1, a2, k;
    longint n[3];
    longint num, fr;
    a1 = axis_of(p.fc);
    a2 = axis_of(q.fc);
    k = 3 - a1 - a2;
    fr = 0;
    n[0] = p.p[1] * q.p[2] - p.p[2] * q.p[1];
    n[1] = p.p[2] * q.p[0] - p.p[0] * q.p[2];
    n[2] = p.p[0] * q.p[1] - p.p[1] * q.p[0];
    num = n[a1] * sign_of(p.fc) + n[a2] * sign_of(q.fc);
    if (n[k] != 0) begin
      fr = div_round(-num * HQ, n[k]);
      if (fr > HQ) fr = HQ;
      if (fr < -HQ) fr = -HQ;
    end
    e.p[a1] = sign_of(p.fc) * HQ;
    e.p[a2] = sign_of(q.fc) * HQ;
    e.p[k] = fr;
    e.fc = q.fc;
    return e;
  endfunction

  function automatic longint clamp_unit(longint x);
    return x < 0 ? 0 : (x > OQ ? OQ : x);
  endfunction

  function automatic longint sat16(longint x);
    return x > 65535 ? 65535 : x;
  endfunction

  // all face rectangles of one beam, in face order
  function automatic void predict_rects(beam_t b, ref res_t rects[$]);
    cpt_t corner[4];
    cpt_t outline[$];
    cpt_t prv;
    bit bad;
    int mask;
    int ua[6] = '{0, 2, 0, 2, 0, 0};
    int us[6] = '{1, -1, 1, 1, 1, -1};
    int va[6] = '{1, 1, 2, 1, 2, 1};
    int vs[6] = '{-1, -1, 1, -1, -1, -1};
    longint s1, s2, t1, t2, u, t, area, w;
    res_t r;
    bad = 1'b0;
    mask = 0;
    rects.delete();
    for (int i = 0; i < 4; i++) project(b.c[3*i], b.c[3*i+1], b.c[3*i+2], corner[i], bad);
    prv = corner[3];
    outline.insert(outline.size(), prv);
    mask |= 1 << prv.fc;
    for (int i = 0; i < 4; i++) begin
      if (corner[i].fc != prv.fc) begin
        mask |= 1 << corner[i].fc;
        if (axis_of(corner[i].fc) == axis_of(prv.fc)) bad = 1'b1;
        else outline.insert(outline.size(), crossing(prv, corner[i]));
      end
      outline.insert(outline.size(), corner[i]);
      prv = corner[i];
    end
    for (int f = 0; f < 6; f++) begin
      if (!mask[f]) continue;
      foreach (outline[j]) begin
        u = us[f] * outline[j].p[ua[f]] + HQ;
        t = vs[f] * outline[j].p[va[f]] + HQ;
        if (j == 0 || u < s1) s1 = u;
        if (j == 0 || u > s2) s2 = u;
        if (j == 0 || t < t1) t1 = t;
        if (j == 0 || t > t2) t2 = t;
      end
      area = (s2 - s1) * (t2 - t1);
      if (area == 0) w = OQ;
      else begin
        w = (area + 32768) >>> 16;
        if (w == 0) w = 1;
      end
      r.face = face_t'(f);
      r.s_low = 16'(sat16((clamp_unit(s1) + (f % 3) * OQ + 1) / 3));
      r.s_high = 16'(sat16((clamp_unit(s2) + (f % 3) * OQ + 1) / 3));
      r.t_low = 16'(sat16((clamp_unit(t1) + (f / 3) * OQ + 1) >>> 1));
      r.t_high = 16'(sat16((clamp_unit(t2) + (f / 3) * OQ + 1) >>> 1));
      r.weight = 17'(w);
      r.last = (mask >> (f + 1)) == 0;
      r.bad_geometry = bad;
      rects.insert(rects.size(), r);
    end
  endfunction

  task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
    $display("%0t: MISMATCH %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic beam_t mk(int v[12]);
    beam_t b;
    for (int k = 0; k < 12; k++) b.c[k] = coord_t'(v[k]);
    return b;
  endfunction

  function automatic res_t rect(face_t f, int sl, int sh, int tl, int th, int w,
                                bit l, bit bg);
    res_t r;
    r.face = f; r.s_low = 16'(sl); r.s_high = 16'(sh); r.t_low = 16'(tl);
    r.t_high = 16'(th); r.weight = 17'(w); r.last = l; r.bad_geometry = bg;
    return r;
  endfunction

  task automatic add_row(beam_t b, bit has_exp, res_t e0);
    row_t r;
    r.beam = b;
    r.has_exp = has_exp;
    r.exp0 = e0;
    rows.insert(rows.size(), r);
  endtask

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 8) - 4);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return coord_t'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  // beams around one random axis give well-formed footprints on nearby faces
  function automatic beam_t rnd_beam();
    beam_t b;
    int kind, ax, spread, base;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      ax = $urandom_range(0, 2);
      base = $urandom_range(0, 1) ? 20000 : -20000;
      spread = $urandom_range(0, 1) ? 30000 : 12000;
      for (int i = 0; i < 4; i++)
        for (int k = 0; k < 3; k++)
          b.c[3*i+k] = coord_t'((k == ax ? base : 0) + $urandom_range(0, 2*spread) - spread);
    end else begin
      for (int k = 0; k < 12; k++) b.c[k] = rnd_coord(kind - 6);
    end
    return b;
  endfunction

  // returns at the falling edge after acceptance with valid still high
  task automatic drive_beam(beam_t b);
    in_ch.valid <= 1'b1;
    {in_ch.ax, in_ch.ay, in_ch.az} <= {b.c[0], b.c[1], b.c[2]};
    {in_ch.bx, in_ch.by_comp, in_ch.bz} <= {b.c[3], b.c[4], b.c[5]};
    {in_ch.cx, in_ch.cy, in_ch.cz} <= {b.c[6], b.c[7], b.c[8]};
    {in_ch.dx, in_ch.dy, in_ch.dz} <= {b.c[9], b.c[10], b.c[11]};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_gap(int gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send(beam_t b, bit has_exp, res_t e0);
    res_t rects[$];
    res_t first;
    predict_rects(b, rects);
    first = '0;
    if (rects.size() != 0) first = rects[0];
    if (has_exp && (rects.size() == 0 || first != e0))
      report_mismatch("typed-in first rectangle", first, e0);
    // queue before acceptance; results cannot appear before the beam is taken
    foreach (rects[k]) rect_q.insert(rect_q.size(), rects[k]);
    drive_beam(b);
  endtask

  initial begin
    beam_t b;
    res_t none;
    int gap;
    none = '0;
    in_ch.valid = 1'b0;
    {in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by_comp, in_ch.bz} = '0;
    {in_ch.cx, in_ch.cy, in_ch.cz, in_ch.dx, in_ch.dy, in_ch.dz} = '0;
    // all corners zero: +z center, flagged
    add_row(mk('{0,0,0, 0,0,0, 0,0,0, 0,0,0}), 1'b1,
            rect(FACE_PZ, 10923, 10923, 16384, 16384, 65536, 1'b1, 1'b1));
    add_row(mk('{0,0,100, 0,0,100, 0,0,100, 0,0,100}), 1'b1,
            rect(FACE_PZ, 10923, 10923, 16384, 16384, 65536, 1'b1, 1'b0));
    add_row(mk('{0,0,-5, 0,0,-5, 0,0,-5, 0,0,-5}), 1'b1,
            rect(FACE_NZ, 54613, 54613, 49152, 49152, 65536, 1'b1, 1'b0));
    // whole +z face: corners on the cube corners
    add_row(mk('{-1,-1,1, 1,-1,1, 1,1,1, -1,1,1}), 1'b1,
            rect(FACE_PZ, 0, 21845, 0, 32768, 65536, 1'b1, 1'b0));
    // extremes of the fields
    add_row(mk('{32767,32767,32767, -32768,-32768,-32768, 32767,-32768,0,
                 -32768,32767,0}), 1'b0, none);
    add_row(mk('{32767,0,0, 0,32767,0, -32768,0,0, 0,-32768,0}), 1'b0, none);
    // opposite faces
    add_row(mk('{0,0,10, 0,0,-10, 0,0,10, 0,0,-10}), 1'b0, none);
    add_row(mk('{10,0,0, -10,0,0, 0,10,0, 0,-10,0}), 1'b0, none);
    // axis ties
    add_row(mk('{5,5,5, 5,5,0, -5,-5,0, 5,-5,-5}), 1'b0, none);
    // plane parallel to edge, and edge points off the edge
    add_row(mk('{1,0,1, 1,0,-1, 1,0,1, 2,0,1}), 1'b0, none);
    add_row(mk('{100,1,99, 99,-1,100, 100,30000,99, 99,-30000,100}), 1'b0, none);
    add_row(mk('{1000,0,999, 999,0,1000, 1000,1,999, 999,1,1000}), 1'b0, none);
    add_row(mk('{0,0,1, 0,0,0, 3,4,5, -3,-4,-5}), 1'b0, none);
    @(negedge clk);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    foreach (rows[i]) begin
      send(rows[i].beam, rows[i].has_exp, rows[i].exp0);
      gap = $urandom_range(0, 8);
      idle_gap(gap);
    end
    for (int n = 0; n < 107; n++) begin
      if (n == 40) long_hold = 1'b1;
      b = rnd_beam();
      send(b, 1'b0, none);
      gap = (n % 30 < 10) ? 0 : $urandom_range(0, 8);
      idle_gap(gap);
    end
    in_ch.valid <= 1'b0;
    send_done = 1'b1;
  end

  // receiver
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (1500) @(negedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rect_q.size() == 0) begin
        report_mismatch("rectangle with nothing queued, face", out_ch.face, 0);
      end else begin
        e = rect_q.pop_front();
        if (out_ch.face !== e.face) report_mismatch("face", out_ch.face, e.face);
        if (out_ch.s_low !== e.s_low) report_mismatch("s_low", out_ch.s_low, e.s_low);
        if (out_ch.s_high !== e.s_high) report_mismatch("s_high", out_ch.s_high, e.s_high);
        if (out_ch.t_low !== e.t_low) report_mismatch("t_low", out_ch.t_low, e.t_low);
        if (out_ch.t_high !== e.t_high) report_mismatch("t_high", out_ch.t_high, e.t_high);
        if (out_ch.weight !== e.weight) report_mismatch("weight", out_ch.weight, e.weight);
        if (out_ch.last !== e.last) report_mismatch("last", out_ch.last, e.last);
        if (out_ch.bad_geometry !== e.bad_geometry)
          report_mismatch("bad_geometry", out_ch.bad_geometry, e.bad_geometry);
      end
    end
  end

  initial begin
    wait (send_done);
    while (rect_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
